/* hdl/s5c_pkg.sv */
`timescale 1ns / 1ps

package s5c_pkg;

    // Input commands
    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_RX    = 2'd1,
        CMD_LOAD  = 2'd2
    } t_cmd;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_USER_LEN   = 3'd0,
        REG_PASS_LEN   = 3'd1,
        REG_ADDR_IS_V6 = 3'd2,
        REG_DEST_PORT  = 3'd3,
        REG_ADDR_UPPER = 3'd4,
        REG_ADDR_LOWER = 3'd5
    } t_cfg_reg;

    typedef enum logic [3:0] {
        ST_BUSY       = 4'd0,
        ST_CONNECTED  = 4'd1,
        ST_DONE       = 4'd2,
        ST_BAD_VER    = 4'd3,
        ST_BAD_METHOD = 4'd4,
        ST_BAD_SUBNEG = 4'd5,
        ST_AUTH_REJ   = 4'd6,
        ST_INVALID    = 4'd7,
        ST_SERVER_ERR = 4'd8,
        ST_RSV_NZ     = 4'd9
    } t_status;

    typedef enum logic [5:0] {
        PH_IDLE  = 6'b000001,
        PH_GREET = 6'b000010,
        PH_PASS  = 6'b000100,
        PH_CONN  = 6'b001000,
        PH_DONE  = 6'b010000,
        PH_FAIL  = 6'b100000
    } t_phase;

    typedef enum logic [3:0] {
        JOB_IDLE  = 4'b0001,
        JOB_GREET = 4'b0010,
        JOB_AUTH  = 4'b0100,
        JOB_CONN  = 4'b1000
    } t_job;

    // Protocol bytes
    localparam logic [7:0] SOCKS_VER       = 8'h05;
    localparam logic [7:0] SUBNEG_VER      = 8'h01;
    localparam logic [7:0] METHOD_NONE     = 8'h00;
    localparam logic [7:0] METHOD_USERPASS = 8'h02;
    localparam logic [7:0] REQ_CONNECT     = 8'h01;
    localparam logic [7:0] ATYP_V4         = 8'h01;
    localparam logic [7:0] ATYP_V6         = 8'h04;
    localparam logic [7:0] BYTE_ZERO       = 8'h00;

    // Reply lengths through the bound port, counted from the version byte
    localparam logic [4:0] REPLY_LEN_V4 = 5'd10;
    localparam logic [4:0] REPLY_LEN_V6 = 5'd22;

    localparam int CRED_AW = 5;
    localparam int STEP_W  = 6;

    // Request from the parser to the transmit sequencer
    typedef struct packed {
        logic       go;
        logic       single;
        t_status    status;
        logic [7:0] code;
        t_job       job;
    } t_emit_req;

    typedef struct packed {
        logic               en;
        logic [CRED_AW-1:0] addr;
        logic [7:0]         data;
    } t_cred_wr;

endpackage

/* hdl/s5c_in_if.sv */
`timescale 1ns / 1ps

interface s5c_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic [7:0] data_byte;
    logic       cred_is_password;
    logic [3:0] cred_index;

    modport source (output valid, cmd, data_byte, cred_is_password, cred_index, input ready);
    modport sink   (input valid, cmd, data_byte, cred_is_password, cred_index, output ready);
endinterface

/* hdl/s5c_out_if.sv */
`timescale 1ns / 1ps

interface s5c_out_if;
    logic       valid;
    logic       ready;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       last;
    logic [3:0] status;
    logic [7:0] reply_code;

    modport source (output valid, tx_valid, tx_byte, last, status, reply_code, input ready);
    modport sink   (input valid, tx_valid, tx_byte, last, status, reply_code, output ready);
endinterface

/* hdl/s5c_cfg_if.sv */
`timescale 1ns / 1ps

interface s5c_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [63:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* hdl/s5c_emit.sv */
`timescale 1ns / 1ps

module s5c_emit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  s5c_pkg::t_emit_req    i_req,
    input  s5c_pkg::t_cred_wr     i_wr,
    input  logic [3:0]            i_user_len,
    input  logic [3:0]            i_pass_len,
    input  logic                  i_with_user,
    input  logic                  i_addr_v6,
    input  logic [15:0]           i_port,
    input  logic [127:0]          i_addr,
    output logic                  o_in_ready,
    s5c_out_if.source             o_out
);

    logic [7:0] r_cred_mem [2**s5c_pkg::CRED_AW];
    logic [7:0] r_rdata;

    s5c_pkg::t_job              r_job;
    logic [s5c_pkg::STEP_W-1:0] r_step;
    logic                       r_o_valid;
    logic                       r_o_txv;
    logic [7:0]                 r_o_byte;
    logic                       r_o_use_mem;
    logic                       r_o_last;
    s5c_pkg::t_status           r_o_status;
    logic [7:0]                 r_o_code;

    logic                       w_adv;
    logic                       w_busy;
    logic [15:0][7:0]           w_addr_b;
    logic [7:0]                 d_byte;
    logic                       d_use_mem;
    logic                       d_last;
    s5c_pkg::t_status           d_status;
    logic [s5c_pkg::CRED_AW-1:0] d_rd_addr;
    logic [s5c_pkg::STEP_W-1:0] w_ul;
    logic [s5c_pkg::STEP_W-1:0] w_pl;
    logic [s5c_pkg::STEP_W-1:0] w_conn_len;
    logic [3:0]                 w_addr_idx;
    logic [s5c_pkg::STEP_W-1:0] w_user_off;
    logic [s5c_pkg::STEP_W-1:0] w_pass_off;

    assign w_adv      = !r_o_valid || o_out.ready;
    assign w_busy     = (r_job != s5c_pkg::JOB_IDLE);
    assign o_in_ready = !w_busy && w_adv;
    assign w_addr_b   = i_addr;

    assign w_ul       = {2'b00, i_user_len};
    assign w_pl       = {2'b00, i_pass_len};
    assign w_conn_len = i_addr_v6 ? 6'(s5c_pkg::REPLY_LEN_V6) : 6'(s5c_pkg::REPLY_LEN_V4);
    // IPv4 bytes sit in the low four bytes of the 128-bit address
    assign w_addr_idx = 4'(r_step - 6'd4) + (i_addr_v6 ? 4'd0 : 4'd12);
    assign w_user_off = r_step - 6'd2;
    assign w_pass_off = r_step - 6'd3 - w_ul;

    always_comb begin
        d_byte    = s5c_pkg::BYTE_ZERO;
        d_use_mem = 1'b0;
        d_last    = 1'b0;
        d_status  = s5c_pkg::ST_BUSY;
        d_rd_addr = {1'b0, w_user_off[3:0]};
        case (r_job)
            s5c_pkg::JOB_GREET: begin
                case (r_step[1:0])
                    2'd0: d_byte = s5c_pkg::SOCKS_VER;
                    2'd1: d_byte = i_with_user ? 8'd2 : 8'd1;
                    2'd2: d_byte = s5c_pkg::METHOD_NONE;
                    default: d_byte = s5c_pkg::METHOD_USERPASS;
                endcase
                d_last = (r_step == (i_with_user ? 6'd3 : 6'd2));
            end
            s5c_pkg::JOB_CONN: begin
                d_status = s5c_pkg::ST_CONNECTED;
                d_last   = (r_step == w_conn_len - 6'd1);
                if (r_step == 6'd0) begin
                    d_byte = s5c_pkg::SOCKS_VER;
                end else if (r_step == 6'd1) begin
                    d_byte = s5c_pkg::REQ_CONNECT;
                end else if (r_step == 6'd2) begin
                    d_byte = s5c_pkg::BYTE_ZERO;
                end else if (r_step == 6'd3) begin
                    d_byte = i_addr_v6 ? s5c_pkg::ATYP_V6 : s5c_pkg::ATYP_V4;
                end else if (r_step == w_conn_len - 6'd2) begin
                    d_byte = i_port[15:8];
                end else if (r_step == w_conn_len - 6'd1) begin
                    d_byte = i_port[7:0];
                end else begin
                    d_byte = w_addr_b[~w_addr_idx];
                end
            end
            s5c_pkg::JOB_AUTH: begin
                d_last = (r_step == 6'd2 + w_ul + w_pl);
                if (r_step == 6'd0) begin
                    d_byte = s5c_pkg::SUBNEG_VER;
                end else if (r_step == 6'd1) begin
                    d_byte = {4'd0, i_user_len};
                end else if (r_step < 6'd2 + w_ul) begin
                    d_use_mem = 1'b1;
                end else if (r_step == 6'd2 + w_ul) begin
                    d_byte = {4'd0, i_pass_len};
                end else begin
                    d_use_mem = 1'b1;
                    d_rd_addr = {1'b1, w_pass_off[3:0]};
                end
            end
            default: begin
                d_byte = s5c_pkg::BYTE_ZERO;
            end
        endcase
    end

    // Stores are taken only while the sequencer is idle, so a write never
    // meets a read of the same entry.
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_cred_mem[i_wr.addr] <= i_wr.data;
        end
        if (w_adv && w_busy && d_use_mem) begin
            r_rdata <= r_cred_mem[d_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job     <= s5c_pkg::JOB_IDLE;
            r_step    <= '0;
            r_o_valid <= 1'b0;
        end else if (w_adv) begin
            if (w_busy) begin
                r_o_valid <= 1'b1;
                r_step    <= r_step + 6'd1;
                if (d_last) begin
                    r_job <= s5c_pkg::JOB_IDLE;
                end
            end else if (i_req.go && i_req.single) begin
                r_o_valid <= 1'b1;
            end else begin
                r_o_valid <= 1'b0;
                if (i_req.go && i_req.job != s5c_pkg::JOB_IDLE) begin
                    r_job  <= i_req.job;
                    r_step <= '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            if (w_busy) begin
                r_o_txv     <= 1'b1;
                r_o_byte    <= d_byte;
                r_o_use_mem <= d_use_mem;
                r_o_last    <= d_last;
                r_o_status  <= d_status;
                r_o_code    <= 8'd0;
            end else begin
                r_o_txv     <= 1'b0;
                r_o_byte    <= 8'd0;
                r_o_use_mem <= 1'b0;
                r_o_last    <= 1'b1;
                r_o_status  <= i_req.status;
                r_o_code    <= i_req.code;
            end
        end
    end

    assign o_out.valid      = r_o_valid;
    assign o_out.tx_valid   = r_o_txv;
    assign o_out.tx_byte    = r_o_use_mem ? r_rdata : r_o_byte;
    assign o_out.last       = r_o_last;
    assign o_out.status     = r_o_status;
    assign o_out.reply_code = r_o_code;

endmodule

/* hdl/socks5_client_handshake.sv */
`timescale 1ns / 1ps
// An item with one result shows it in the cycle after the transfer; a request (greeting,
// subnegotiation, CONNECT) first loads the sequencer job, which then registers its bytes.
// Request bytes go out one per cycle while the receiver is ready, credential ones read
// with the output register; single-result and silent items go one per cycle if unstalled.
// Reset: synchronous, active low; clears phase, counters, registers and the output
// stage. The credential memory is not cleared.

module socks5_client_handshake #(
    parameter int MAX_CRED_LEN = 15
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    s5c_in_if.sink      i_in,
    s5c_cfg_if.sink     i_cfg,
    s5c_out_if.source   o_out
);

    localparam int         CLAMP_I = (MAX_CRED_LEN > 15) ? 15 : MAX_CRED_LEN;
    localparam logic [3:0] CLAMP_L = 4'(CLAMP_I);

    logic [3:0]   r_user_len;
    logic [3:0]   r_pass_len;
    logic         r_addr_v6;
    logic [15:0]  r_dest_port;
    logic [63:0]  r_addr_upper;
    logic [63:0]  r_addr_lower;

    s5c_pkg::t_phase r_phase, n_phase;
    logic [4:0]      r_byte_count, n_byte_count;
    logic            r_reply_v6, n_reply_v6;

    s5c_pkg::t_emit_req w_req;
    s5c_pkg::t_cred_wr  w_wr;
    logic               w_in_ready;
    logic               w_accept;
    logic [3:0]         w_ul;
    logic [3:0]         w_pl;
    logic [7:0]         w_b;
    logic [4:0]         w_cnt_inc;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = w_in_ready;
    assign w_accept    = i_in.valid && w_in_ready;
    assign w_b         = i_in.data_byte;
    assign w_cnt_inc   = r_byte_count + 5'd1;

    assign w_ul = (r_user_len > CLAMP_L) ? CLAMP_L : r_user_len;
    assign w_pl = (r_pass_len > CLAMP_L) ? CLAMP_L : r_pass_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_user_len   <= '0;
            r_pass_len   <= '0;
            r_addr_v6    <= 1'b0;
            r_dest_port  <= '0;
            r_addr_upper <= '0;
            r_addr_lower <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                s5c_pkg::REG_USER_LEN:   r_user_len   <= i_cfg.data[3:0];
                s5c_pkg::REG_PASS_LEN:   r_pass_len   <= i_cfg.data[3:0];
                s5c_pkg::REG_ADDR_IS_V6: r_addr_v6    <= i_cfg.data[0];
                s5c_pkg::REG_DEST_PORT:  r_dest_port  <= i_cfg.data[15:0];
                s5c_pkg::REG_ADDR_UPPER: r_addr_upper <= i_cfg.data;
                s5c_pkg::REG_ADDR_LOWER: r_addr_lower <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // Command decoder and reply parser: one received byte per transfer
    always_comb begin
        n_phase      = r_phase;
        n_byte_count = r_byte_count;
        n_reply_v6   = r_reply_v6;
        w_req        = '{go: 1'b0, single: 1'b0, status: s5c_pkg::ST_BUSY,
                         code: 8'd0, job: s5c_pkg::JOB_IDLE};
        w_wr.en      = 1'b0;
        w_wr.addr    = {i_in.cred_is_password, i_in.cred_index};
        w_wr.data    = w_b;
        if (w_accept) begin
            w_req.go = 1'b1;
            case (i_in.cmd)
                s5c_pkg::CMD_START: begin
                    n_phase      = s5c_pkg::PH_GREET;
                    n_byte_count = 5'd0;
                    n_reply_v6   = 1'b0;
                    w_req.job    = s5c_pkg::JOB_GREET;
                end
                s5c_pkg::CMD_LOAD: begin
                    w_wr.en = 1'b1;
                end
                s5c_pkg::CMD_RX: begin
                    case (r_phase)
                        s5c_pkg::PH_GREET: begin
                            if (r_byte_count == 5'd0) begin
                                w_req.single = 1'b1;
                                if (w_b == s5c_pkg::SOCKS_VER) begin
                                    n_byte_count = w_cnt_inc;
                                end else begin
                                    n_phase      = s5c_pkg::PH_FAIL;
                                    w_req.status = s5c_pkg::ST_BAD_VER;
                                end
                            end else if (w_b == s5c_pkg::METHOD_NONE) begin
                                n_phase      = s5c_pkg::PH_CONN;
                                n_byte_count = 5'd0;
                                w_req.job    = s5c_pkg::JOB_CONN;
                            end else if (w_b == s5c_pkg::METHOD_USERPASS) begin
                                n_phase      = s5c_pkg::PH_PASS;
                                n_byte_count = 5'd0;
                                w_req.job    = s5c_pkg::JOB_AUTH;
                            end else begin
                                n_phase      = s5c_pkg::PH_FAIL;
                                w_req.single = 1'b1;
                                w_req.status = s5c_pkg::ST_BAD_METHOD;
                            end
                        end
                        s5c_pkg::PH_PASS: begin
                            if (r_byte_count == 5'd0) begin
                                w_req.single = 1'b1;
                                if (w_b == s5c_pkg::SUBNEG_VER) begin
                                    n_byte_count = w_cnt_inc;
                                end else begin
                                    n_phase      = s5c_pkg::PH_FAIL;
                                    w_req.status = s5c_pkg::ST_BAD_SUBNEG;
                                end
                            end else if (w_b != s5c_pkg::BYTE_ZERO) begin
                                n_phase      = s5c_pkg::PH_FAIL;
                                w_req.single = 1'b1;
                                w_req.status = s5c_pkg::ST_AUTH_REJ;
                            end else begin
                                n_phase      = s5c_pkg::PH_CONN;
                                n_byte_count = 5'd0;
                                w_req.job    = s5c_pkg::JOB_CONN;
                            end
                        end
                        s5c_pkg::PH_CONN: begin
                            w_req.single = 1'b1;
                            n_byte_count = w_cnt_inc;
                            if (r_byte_count == 5'd0) begin
                                if (w_b != s5c_pkg::SOCKS_VER) begin
                                    n_phase      = s5c_pkg::PH_FAIL;
                                    w_req.status = s5c_pkg::ST_INVALID;
                                end
                            end else if (r_byte_count == 5'd1) begin
                                if (w_b != s5c_pkg::BYTE_ZERO) begin
                                    n_phase      = s5c_pkg::PH_FAIL;
                                    w_req.status = s5c_pkg::ST_SERVER_ERR;
                                    w_req.code   = w_b;
                                end
                            end else if (r_byte_count == 5'd2) begin
                                if (w_b != s5c_pkg::BYTE_ZERO) begin
                                    n_phase      = s5c_pkg::PH_FAIL;
                                    w_req.status = s5c_pkg::ST_RSV_NZ;
                                end
                            end else if (r_byte_count == 5'd3) begin
                                if (w_b == s5c_pkg::ATYP_V4) begin
                                    n_reply_v6 = 1'b0;
                                end else if (w_b == s5c_pkg::ATYP_V6) begin
                                    n_reply_v6 = 1'b1;
                                end else begin
                                    n_phase      = s5c_pkg::PH_FAIL;
                                    w_req.status = s5c_pkg::ST_INVALID;
                                end
                            end else if (w_cnt_inc >= (r_reply_v6 ? s5c_pkg::REPLY_LEN_V6
                                                                  : s5c_pkg::REPLY_LEN_V4)) begin
                                n_phase      = s5c_pkg::PH_DONE;
                                n_byte_count = 5'd0;
                                w_req.status = s5c_pkg::ST_DONE;
                            end
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= s5c_pkg::PH_IDLE;
            r_byte_count <= '0;
            r_reply_v6   <= 1'b0;
        end else begin
            r_phase      <= n_phase;
            r_byte_count <= n_byte_count;
            r_reply_v6   <= n_reply_v6;
        end
    end

    s5c_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (w_req),
        .i_wr        (w_wr),
        .i_user_len  (w_ul),
        .i_pass_len  (w_pl),
        .i_with_user (r_user_len != 4'd0),
        .i_addr_v6   (r_addr_v6),
        .i_port      (r_dest_port),
        .i_addr      ({r_addr_upper, r_addr_lower}),
        .o_in_ready  (w_in_ready),
        .o_out       (o_out)
    );

endmodule

/* hdl/s5c_checker.sv */
`timescale 1ns / 1ps

module s5c_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic [1:0] i_in_cmd,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic       i_out_tx_valid,
    input logic [7:0] i_out_tx_byte,
    input logic       i_out_last,
    input logic [3:0] i_out_status,
    input logic [7:0] i_out_reply_code
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_tx_byte) && $stable(i_out_last)))
        else $error("stalled result changed");

    // No new item while a result waits
    a_in_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |-> !i_in_ready)
        else $error("input taken while output stalled");

    // A start launches the greeting, which blocks the input
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && i_in_cmd == s5c_pkg::CMD_START) |=> !i_in_ready)
        else $error("input ready during greeting");

    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_tx_valid) |-> i_out_last)
        else $error("status-only result not marked last");

    a_code_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_reply_code != 8'd0) |-> i_out_status == s5c_pkg::ST_SERVER_ERR)
        else $error("reply code without server error");

endmodule

bind socks5_client_handshake s5c_checker u_s5c_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in.valid),
    .i_in_ready       (i_in.ready),
    .i_in_cmd         (i_in.cmd),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_out_tx_valid   (o_out.tx_valid),
    .i_out_tx_byte    (o_out.tx_byte),
    .i_out_last       (o_out.last),
    .i_out_status     (o_out.status),
    .i_out_reply_code (o_out.reply_code)
);

/* tb/sv/s5c_handshake_checker.sv */
`timescale 1ns / 1ps

module s5c_handshake_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    s5c_in_if    i_in,
    s5c_cfg_if   i_cfg,
    s5c_out_if   i_out,
    output int   o_fail_count,
    output int   o_pending
);
    import s5c_pkg::*;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       last;
        t_status    status;
        logic [7:0] reply_code;
    } t_result;

    localparam int REPORT_MAX = 10;

    // Register shadows
    logic [3:0]  ulen_r;
    logic [3:0]  plen_r;
    logic        dst_v6_r;
    logic [15:0] port_r;
    logic [63:0] addr_hi_r;
    logic [63:0] addr_lo_r;

    // Link state as the client side tracks it
    t_phase      link_ph;
    logic [4:0]  rx_cnt;
    logic        bound_v6;
    logic [7:0]  cred_mem [32];

    t_result     burst[$];
    t_result     results_due[$];
    int          reported;

    task automatic add_result(input logic v, input logic [7:0] b, input t_status st,
                              input logic [7:0] code);
        t_result r;
        r.tx_valid   = v;
        r.tx_byte    = b;
        r.last       = 1'b0;
        r.status     = st;
        r.reply_code = code;
        burst.push_back(r);
    endtask

    task automatic accept_rx();
        rx_cnt = rx_cnt + 5'd1;
        add_result(1'b0, 8'h00, ST_BUSY, 8'h00);
    endtask

    task automatic flag_error(input t_status st, input logic [7:0] code);
        link_ph = PH_FAIL;
        add_result(1'b0, 8'h00, st, code);
    endtask

    task automatic emit_connect();
        add_result(1'b1, SOCKS_VER, ST_CONNECTED, 8'h00);
        add_result(1'b1, REQ_CONNECT, ST_CONNECTED, 8'h00);
        add_result(1'b1, BYTE_ZERO, ST_CONNECTED, 8'h00);
        if (dst_v6_r) begin
            add_result(1'b1, ATYP_V6, ST_CONNECTED, 8'h00);
            for (int i = 7; i >= 0; i--)
                add_result(1'b1, addr_hi_r[8*i +: 8], ST_CONNECTED, 8'h00);
            for (int i = 7; i >= 0; i--)
                add_result(1'b1, addr_lo_r[8*i +: 8], ST_CONNECTED, 8'h00);
        end else begin
            add_result(1'b1, ATYP_V4, ST_CONNECTED, 8'h00);
            for (int i = 3; i >= 0; i--)
                add_result(1'b1, addr_lo_r[8*i +: 8], ST_CONNECTED, 8'h00);
        end
        add_result(1'b1, port_r[15:8], ST_CONNECTED, 8'h00);
        add_result(1'b1, port_r[7:0], ST_CONNECTED, 8'h00);
        link_ph = PH_CONN;
        rx_cnt  = 5'd0;
    endtask

    task automatic predict_exchange(input logic [1:0] cmd, input logic [7:0] b,
                                    input logic pw, input logic [3:0] idx);
        t_result r;
        burst.delete();
        if (cmd == CMD_START) begin
            add_result(1'b1, SOCKS_VER, ST_BUSY, 8'h00);
            add_result(1'b1, (ulen_r != 0) ? 8'h02 : 8'h01, ST_BUSY, 8'h00);
            add_result(1'b1, METHOD_NONE, ST_BUSY, 8'h00);
            if (ulen_r != 0)
                add_result(1'b1, METHOD_USERPASS, ST_BUSY, 8'h00);
            link_ph  = PH_GREET;
            rx_cnt   = 5'd0;
            bound_v6 = 1'b0;
        end else if (cmd == CMD_LOAD) begin
            cred_mem[{pw, idx}] = b;
        end else if (cmd == CMD_RX) begin
            case (link_ph)
                PH_GREET: begin
                    if (rx_cnt == 0) begin
                        if (b == SOCKS_VER) accept_rx();
                        else flag_error(ST_BAD_VER, 8'h00);
                    end else if (b == METHOD_NONE) begin
                        emit_connect();
                    end else if (b == METHOD_USERPASS) begin
                        add_result(1'b1, SUBNEG_VER, ST_BUSY, 8'h00);
                        add_result(1'b1, {4'h0, ulen_r}, ST_BUSY, 8'h00);
                        for (int i = 0; i < ulen_r; i++)
                            add_result(1'b1, cred_mem[i], ST_BUSY, 8'h00);
                        add_result(1'b1, {4'h0, plen_r}, ST_BUSY, 8'h00);
                        for (int i = 0; i < plen_r; i++)
                            add_result(1'b1, cred_mem[16 + i], ST_BUSY, 8'h00);
                        link_ph = PH_PASS;
                        rx_cnt  = 5'd0;
                    end else begin
                        flag_error(ST_BAD_METHOD, 8'h00);
                    end
                end
                PH_PASS: begin
                    if (rx_cnt == 0) begin
                        if (b == SUBNEG_VER) accept_rx();
                        else flag_error(ST_BAD_SUBNEG, 8'h00);
                    end else if (b != BYTE_ZERO) begin
                        flag_error(ST_AUTH_REJ, 8'h00);
                    end else begin
                        emit_connect();
                    end
                end
                PH_CONN: begin
                    if (rx_cnt == 0) begin
                        if (b == SOCKS_VER) accept_rx();
                        else flag_error(ST_INVALID, 8'h00);
                    end else if (rx_cnt == 1) begin
                        if (b == BYTE_ZERO) accept_rx();
                        else flag_error(ST_SERVER_ERR, b);
                    end else if (rx_cnt == 2) begin
                        if (b == BYTE_ZERO) accept_rx();
                        else flag_error(ST_RSV_NZ, 8'h00);
                    end else if (rx_cnt == 3) begin
                        if (b == ATYP_V4 || b == ATYP_V6) begin
                            bound_v6 = (b == ATYP_V6);
                            accept_rx();
                        end else begin
                            flag_error(ST_INVALID, 8'h00);
                        end
                    end else if (int'(rx_cnt) + 1 >=
                                 int'(bound_v6 ? REPLY_LEN_V6 : REPLY_LEN_V4)) begin
                        link_ph = PH_DONE;
                        rx_cnt  = 5'd0;
                        add_result(1'b0, 8'h00, ST_DONE, 8'h00);
                    end else begin
                        accept_rx();
                    end
                end
                default: ;
            endcase
        end
        if (burst.size() > 0) begin
            // mark the closing result of this item
            r = burst.pop_back();
            r.last = 1'b1;
            burst.push_back(r);
            foreach (burst[i])
                results_due.push_back(burst[i]);
        end
    endtask

    task automatic check_result();
        t_result want;
        if (results_due.size() == 0) begin
            o_fail_count++;
            if (reported < REPORT_MAX) begin
                reported++;
                $display("%0t: unexpected txv=%0d byte=%02h last=%0d status=%0d code=%02h",
                         $realtime, i_out.tx_valid, i_out.tx_byte, i_out.last, i_out.status,
                         i_out.reply_code);
            end
        end else begin
            want = results_due.pop_front();
            if (i_out.tx_valid !== want.tx_valid || i_out.tx_byte !== want.tx_byte ||
                i_out.last !== want.last || i_out.status !== want.status ||
                i_out.reply_code !== want.reply_code) begin
                o_fail_count++;
                if (reported < REPORT_MAX) begin
                    reported++;
                    $display("%0t: expected txv=%0d byte=%02h last=%0d status=%0d code=%02h",
                             $realtime, want.tx_valid, want.tx_byte, want.last, want.status,
                             want.reply_code);
                    $display("%0t: actual   txv=%0d byte=%02h last=%0d status=%0d code=%02h",
                             $realtime, i_out.tx_valid, i_out.tx_byte, i_out.last, i_out.status,
                             i_out.reply_code);
                end
            end
        end
    endtask

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        reported     = 0;
        foreach (cred_mem[i])
            cred_mem[i] = 8'h00;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            ulen_r    = 4'd0;
            plen_r    = 4'd0;
            dst_v6_r  = 1'b0;
            port_r    = 16'd0;
            addr_hi_r = 64'd0;
            addr_lo_r = 64'd0;
            link_ph   = PH_IDLE;
            rx_cnt    = 5'd0;
            bound_v6  = 1'b0;
            results_due.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    REG_USER_LEN:   ulen_r    = i_cfg.data[3:0];
                    REG_PASS_LEN:   plen_r    = i_cfg.data[3:0];
                    REG_ADDR_IS_V6: dst_v6_r  = i_cfg.data[0];
                    REG_DEST_PORT:  port_r    = i_cfg.data[15:0];
                    REG_ADDR_UPPER: addr_hi_r = i_cfg.data;
                    REG_ADDR_LOWER: addr_lo_r = i_cfg.data;
                    default: ;
                endcase
            end
            if (i_in.valid && i_in.ready)
                predict_exchange(i_in.cmd, i_in.data_byte, i_in.cred_is_password,
                                 i_in.cred_index);
            if (i_out.valid && i_out.ready)
                check_result();
        end
        o_pending = results_due.size();
    end

endmodule

/* tb/sv/socks5_client_handshake_tb.sv */
`timescale 1ns / 1ps

module socks5_client_handshake_tb;
    import s5c_pkg::*;

    localparam int         CYCLE_LIMIT = 500000;
    localparam logic [1:0] CMD_UNUSED  = 2'd3;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   items_sent;
    int   snd_idle_pct;
    int   rcv_stall_pct;
    int   cycle_cnt;

    s5c_in_if  in_ch ();
    s5c_cfg_if cfg_ch ();
    s5c_out_if out_ch ();

    socks5_client_handshake #(
        .MAX_CRED_LEN(15)
    ) DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .i_cfg  (cfg_ch),
        .o_out  (out_ch)
    );

    s5c_handshake_checker chk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch),
        .i_cfg       (cfg_ch),
        .i_out       (out_ch),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Receiver back-pressure
    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            out_ch.ready <= ($urandom_range(99) >= rcv_stall_pct);
        end
    end

    initial begin
        for (cycle_cnt = 0; cycle_cnt < CYCLE_LIMIT; cycle_cnt++)
            @(posedge i_clk);
        $display("socks5_client_handshake test failed");
        $finish;
    end

    // Keep valid high between back-to-back items; drop it only for a gap
    task automatic send_item(input logic [1:0] c, input logic [7:0] b, input logic pw,
                             input logic [3:0] idx);
        while ($urandom_range(99) < snd_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid            <= 1'b1;
        in_ch.cmd              <= c;
        in_ch.data_byte        <= b;
        in_ch.cred_is_password <= pw;
        in_ch.cred_index       <= idx;
        do @(posedge i_clk); while (!in_ch.ready);
        items_sent++;
    endtask

    task automatic send_rx(input logic [7:0] b);
        send_item(CMD_RX, b, 1'($urandom_range(1)), 4'($urandom_range(15)));
    endtask

    task automatic send_start();
        send_item(CMD_START, 8'($urandom_range(255)), 1'($urandom_range(1)),
                  4'($urandom_range(15)));
    endtask

    task automatic send_load();
        send_item(CMD_LOAD, 8'($urandom_range(255)), 1'($urandom_range(1)),
                  4'($urandom_range(15)));
    endtask

    task automatic program_regs(input logic [3:0] ulen, input logic [3:0] plen,
                                input logic v6, input logic [15:0] port,
                                input logic [63:0] hi, input logic [63:0] lo);
        logic [63:0] vals [6];
        vals[REG_USER_LEN]   = {60'd0, ulen};
        vals[REG_PASS_LEN]   = {60'd0, plen};
        vals[REG_ADDR_IS_V6] = {63'd0, v6};
        vals[REG_DEST_PORT]  = {48'd0, port};
        vals[REG_ADDR_UPPER] = hi;
        vals[REG_ADDR_LOWER] = lo;
        for (int k = 0; k < 6; k++) begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= k[2:0];
            cfg_ch.data  <= vals[k];
            do @(posedge i_clk); while (!cfg_ch.ready);
        end
        cfg_ch.valid <= 1'b0;
    endtask

    // Wait out every expected result plus the tail of any silent item
    task automatic drain();
        in_ch.valid <= 1'b0;
        repeat (2) @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic run_session();
        logic [7:0] rx_seq[$];
        logic       use_auth;
        logic       v6_reply;
        int         cut;
        use_auth = 1'($urandom_range(1));
        v6_reply = 1'($urandom_range(1));
        rx_seq.push_back(SOCKS_VER);
        if (use_auth) begin
            rx_seq.push_back(METHOD_USERPASS);
            rx_seq.push_back(SUBNEG_VER);
            rx_seq.push_back(BYTE_ZERO);
        end else begin
            rx_seq.push_back(METHOD_NONE);
        end
        rx_seq.push_back(SOCKS_VER);
        rx_seq.push_back(BYTE_ZERO);
        rx_seq.push_back(BYTE_ZERO);
        rx_seq.push_back(v6_reply ? ATYP_V6 : ATYP_V4);
        repeat (v6_reply ? 18 : 6) rx_seq.push_back(8'($urandom_range(255)));
        // corrupt one byte in a quarter of the sessions
        if ($urandom_range(3) == 0) begin
            cut = int'($urandom_range(rx_seq.size() - 1));
            rx_seq[cut] = 8'($urandom_range(255));
        end
        repeat ($urandom_range(2)) rx_seq.push_back(8'($urandom_range(255)));
        send_start();
        foreach (rx_seq[i]) begin
            if ($urandom_range(19) == 0)
                send_load();
            if ($urandom_range(59) == 0)
                send_start();
            send_rx(rx_seq[i]);
        end
    endtask

    initial begin
        int target;
        i_rst_n                <= 1'b0;
        in_ch.valid            <= 1'b0;
        in_ch.cmd              <= CMD_START;
        in_ch.data_byte        <= 8'h00;
        in_ch.cred_is_password <= 1'b0;
        in_ch.cred_index       <= 4'd0;
        cfg_ch.valid           <= 1'b0;
        cfg_ch.index           <= REG_USER_LEN;
        cfg_ch.data            <= 64'd0;
        items_sent    = 0;
        snd_idle_pct  = 0;
        rcv_stall_pct = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        program_regs(4'd15, 4'd15, 1'b1, 16'hFFFF, '1, 64'd0);
        // fill the whole credential store before anything can read it
        for (int k = 0; k < 32; k++) begin
            logic [4:0] a;
            a = k[4:0];
            send_item(CMD_LOAD, 8'($urandom_range(255)), a[4], a[3:0]);
        end

        // Directed: ignored items, then error paths from a fresh start, all but reserved-byte and address-type
        send_rx(8'h05);
        send_item(CMD_UNUSED, 8'hFF, 1'b1, 4'd15);
        send_start();
        send_rx(8'h06);
        send_start();
        send_rx(SOCKS_VER);
        send_rx(8'h01);
        send_start();
        send_rx(SOCKS_VER);
        send_rx(METHOD_USERPASS);
        send_rx(8'h02);
        send_start();
        send_rx(SOCKS_VER);
        send_rx(METHOD_USERPASS);
        send_rx(SUBNEG_VER);
        send_rx(8'hFF);
        send_start();
        send_rx(SOCKS_VER);
        send_rx(METHOD_NONE);
        send_rx(ATYP_V6);
        send_start();
        send_rx(SOCKS_VER);
        send_rx(METHOD_NONE);
        send_rx(SOCKS_VER);
        send_rx(8'h5A);

        for (int p = 0; p < 6; p++) begin
            drain();
            case (p)
                0: program_regs(4'd15, 4'd15, 1'b1, 16'hFFFF, '1, '1);
                1: program_regs(4'd0, 4'd0, 1'b0, 16'h0000, 64'd0, 64'd0);
                2: program_regs(4'd0, 4'($urandom_range(15)), 1'b0,
                                16'($urandom_range(65535)),
                                {$urandom, $urandom}, {$urandom, $urandom});
                default: program_regs(4'($urandom_range(15)), 4'($urandom_range(15)),
                                      1'($urandom_range(1)), 16'($urandom_range(65535)),
                                      {$urandom, $urandom}, {$urandom, $urandom});
            endcase
            case (p % 4)
                0: begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
                1: begin snd_idle_pct = 56; rcv_stall_pct = 0;  end
                2: begin snd_idle_pct = 0;  rcv_stall_pct = 56; end
                default: begin snd_idle_pct = 18; rcv_stall_pct = 18; end
            endcase
            target = items_sent + 55;
            while (items_sent < target) begin
                if ($urandom_range(7) == 0) begin
                    repeat ($urandom_range(1, 4))
                        send_item(2'($urandom_range(3)), 8'($urandom_range(255)),
                                  1'($urandom_range(1)), 4'($urandom_range(15)));
                end else begin
                    run_session();
                end
            end
        end

        drain();
        if (fail_count == 0 && pending == 0)
            $display("socks5_client_handshake test passed");
        else
            $display("socks5_client_handshake test failed");
        $finish;
    end

endmodule
